// File: hw/rtl/dlpoh_pkg.sv
`timescale 1ns / 1ps

package dlpoh_pkg;

  localparam int unsigned TIMER_W   = 27;
  localparam int unsigned ACC_W     = 24;
  localparam int unsigned SEC_W     = 32;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CFG_W     = 27;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [ACC_W-1:0] ACC_MAX      = 24'hFFFFFF;
  localparam logic [CFG_W-1:0] PERIOD_RESET = 27'd80000000;

  typedef enum logic [CMD_W-1:0] {
    CMD_EDGE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD    = 2'd0,
    REG_SEC_NOTE  = 2'd1,
    REG_HIST_NOTE = 2'd2
  } reg_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic               channel;
    logic               level;
    logic [TIMER_W-1:0] timer_value;
    logic [IDX_W-1:0]   index;
  } in_t;

  typedef struct packed {
    logic [ACC_W-1:0] first_low_us;
    logic [ACC_W-1:0] second_low_us;
    logic [SEC_W-1:0] seconds_elapsed;
    logic             second_note;
    logic             history_note;
  } out_t;

endpackage

// File: hw/rtl/dlpoh_if.sv
`timescale 1ns / 1ps

interface dlpoh_in_if;
  logic            valid;
  logic            ready;
  dlpoh_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dlpoh_out_if;
  logic            valid;
  logic            ready;
  dlpoh_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/dual_low_pulse_occupancy_history.sv
`timescale 1ns / 1ps

// Dual low-pulse occupancy meter with a per-second history ring.
// in_i carries edge, tick and read-history beats; out_o returns exactly one
// result beat per input beat, in order. Configuration is written through
// cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
// A result is visible on out_o once its input beat has passed the input
// register (loaded at the edge at which the beat is accepted), the
// elapsed-time stage, the reciprocal multiply and ring read stage, and the
// result queue. Throughput: one beat per cycle while in_i.ready is high;
// the multiply stage and the ring's single read port both run every cycle.
// Up to 8 beats may be outstanding; the result queue absorbs them, so input
// beats keep being taken while a result waits, and ready drops only when
// 8 results are owed to the receiver.
// Reset: accumulators, pending falls, second count and ring pointer clear,
// the registers return to their reset values. The ring is not swept: a fill
// count makes never-written entries read as zero, so the block accepts beats
// right after reset.
module dual_low_pulse_occupancy_history #(
  parameter int unsigned HISTORY_DEPTH = 64,
  parameter int unsigned TICKS_PER_US  = 80
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dlpoh_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dlpoh_pkg::CFG_W-1:0]          cfg_data_i,
  dlpoh_in_if.sink                             in_i,
  dlpoh_out_if.source                          out_o
);

  localparam int unsigned TW      = dlpoh_pkg::TIMER_W;
  localparam int unsigned AW      = dlpoh_pkg::ACC_W;
  localparam int unsigned PTR_W   = $clog2(HISTORY_DEPTH);
  localparam int unsigned FILL_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SEL_W   = ((PTR_W > dlpoh_pkg::IDX_W) ? PTR_W : dlpoh_pkg::IDX_W) + 1;
  localparam int unsigned DIV_SH  = TW + $clog2(TICKS_PER_US);
  localparam int unsigned RECIP_W = TW + 1;
  localparam int unsigned PROD_W  = TW + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << DIV_SH) + 64'(TICKS_PER_US) - 64'd1) / 64'(TICKS_PER_US);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = 3;
  localparam int unsigned CNT_W      = 4;
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);
  localparam logic [SEL_W-1:0]  DEPTH_SEL = SEL_W'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(FIFO_DEPTH);

  typedef struct packed {
    logic [dlpoh_pkg::CMD_W-1:0] cmd;
    logic                        ch;
    logic                        add;
    logic [dlpoh_pkg::IDX_W-1:0] idx;
    logic [TW-1:0]               elapsed;
  } s2_t;

  typedef struct packed {
    logic [dlpoh_pkg::CMD_W-1:0] cmd;
    logic                        ch;
    logic                        add;
    logic [TW-1:0]               quot;
  } s3_t;

  // configuration
  logic [dlpoh_pkg::CFG_W-1:0] period_q;
  logic                        sne_q, hne_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= dlpoh_pkg::PERIOD_RESET;
      sne_q    <= 1'b0;
      hne_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dlpoh_pkg::REG_PERIOD:    period_q <= cfg_data_i;
        dlpoh_pkg::REG_SEC_NOTE:  sne_q    <= cfg_data_i[0];
        dlpoh_pkg::REG_HIST_NOTE: hne_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshakes and outstanding count
  logic             in_acc, out_acc;
  logic [CNT_W-1:0] credit_q, credit_d;
  logic [CNT_W-1:0] fcnt_q;

  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign in_i.ready = (credit_q != CNT_FULL);
  assign credit_d   = credit_q + CNT_W'(in_acc) - CNT_W'(out_acc);

  // pipeline registers
  logic           s1_v_q, s2_v_q, s3_v_q;
  dlpoh_pkg::in_t s1_q;
  s2_t            s2_q, s2_d;
  s3_t            s3_q, s3_d;

  // edge state
  logic [1:0][TW-1:0] stamp_q, stamp_d;
  logic [1:0]         fv_q, fv_d;
  logic [1:0][AW-1:0] acc_q, acc_d;

  // ring state
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [dlpoh_pkg::SEC_W-1:0] sec_q, sec_d;
  logic [AW-1:0]     h0_mem [HISTORY_DEPTH];
  logic [AW-1:0]     h1_mem [HISTORY_DEPTH];
  logic [AW-1:0]     rd0_q, rd1_q, bp0_q, bp1_q;
  logic              byp_q, rok_q;
  logic              wr_en;

  // stage 1: elapsed ticks and fall bookkeeping
  logic [TW-1:0] stamp_sel, now1, elapsed1;
  logic [TW:0]   diff1;
  logic [TW+1:0] wsum1;
  logic          is_edge1, rise_hit1;

  assign now1      = s1_q.timer_value;
  assign stamp_sel = stamp_q[s1_q.channel];
  assign diff1     = {1'b0, now1} - {1'b0, stamp_sel};
  assign wsum1     = {2'b00, period_q} + {2'b00, now1} - {2'b00, stamp_sel};
  assign elapsed1  = !diff1[TW] ? diff1[TW-1:0] :
                     (wsum1[TW+1] ? '0 : wsum1[TW-1:0]);
  assign is_edge1  = s1_v_q && (s1_q.cmd == dlpoh_pkg::CMD_EDGE);
  assign rise_hit1 = is_edge1 && s1_q.level && fv_q[s1_q.channel];

  always_comb begin
    stamp_d = stamp_q;
    fv_d    = fv_q;
    if (is_edge1) begin
      if (!s1_q.level) begin
        stamp_d[s1_q.channel] = now1;
        fv_d[s1_q.channel]    = 1'b1;
      end else begin
        fv_d[s1_q.channel] = 1'b0;
      end
    end
    s2_d.cmd     = s1_q.cmd;
    s2_d.ch      = s1_q.channel;
    s2_d.add     = rise_hit1;
    s2_d.idx     = s1_q.index;
    s2_d.elapsed = elapsed1;
  end

  // stage 2: divide by reciprocal multiply, ring read address
  logic [PROD_W-1:0] prod2, quot2;
  logic [SEL_W-1:0]  idx2, sel2, slot_sum2, slot2;
  logic [PTR_W-1:0]  rd_addr;
  logic              rok2, byp2;

  assign prod2     = PROD_W'(s2_q.elapsed) * PROD_W'(RECIP);
  assign quot2     = prod2 >> DIV_SH;
  assign idx2      = SEL_W'(s2_q.idx);
  assign sel2      = (idx2 >= DEPTH_SEL) ? (DEPTH_SEL - SEL_W'(1)) : idx2;
  assign slot_sum2 = sel2 + SEL_W'(ptr_d);
  assign slot2     = (slot_sum2 >= DEPTH_SEL) ? (slot_sum2 - DEPTH_SEL) : slot_sum2;
  assign rd_addr   = slot2[PTR_W-1:0];
  assign rok2      = slot2 < SEL_W'(fill_d);
  assign byp2      = wr_en && (rd_addr == ptr_q);

  always_comb begin
    s3_d.cmd  = s2_q.cmd;
    s3_d.ch   = s2_q.ch;
    s3_d.add  = s2_q.add;
    s3_d.quot = quot2[TW-1:0];
  end

  // stage 3: accumulate, tick, read select
  logic [TW:0]     acc_sum3;
  logic [AW-1:0]   acc_new3, rsel0, rsel1;
  logic            hnote3;
  dlpoh_pkg::out_t res3;

  assign acc_sum3 = (TW + 1)'(acc_q[s3_q.ch]) + (TW + 1)'(s3_q.quot);
  assign acc_new3 = (acc_sum3[TW:AW] != '0) ? dlpoh_pkg::ACC_MAX : acc_sum3[AW-1:0];
  assign rsel0    = byp_q ? bp0_q : (rok_q ? rd0_q : '0);
  assign rsel1    = byp_q ? bp1_q : (rok_q ? rd1_q : '0);

  always_comb begin
    acc_d  = acc_q;
    ptr_d  = ptr_q;
    fill_d = fill_q;
    sec_d  = sec_q;
    wr_en  = 1'b0;
    hnote3 = 1'b0;
    if (s3_v_q) begin
      case (s3_q.cmd)
        dlpoh_pkg::CMD_TICK: begin
          wr_en  = 1'b1;
          acc_d  = '0;
          ptr_d  = (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
          fill_d = (fill_q == FILL_FULL) ? fill_q : fill_q + FILL_W'(1);
          sec_d  = sec_q + 32'd1;
          hnote3 = (ptr_q == PTR_LAST) && hne_q;
        end
        dlpoh_pkg::CMD_EDGE: begin
          if (s3_q.add) begin
            acc_d[s3_q.ch] = acc_new3;
          end
        end
        default: ;
      endcase
    end
    res3.seconds_elapsed = sec_d;
    res3.second_note     = 1'b0;
    res3.history_note    = 1'b0;
    res3.first_low_us    = acc_d[0];
    res3.second_low_us   = acc_d[1];
    case (s3_q.cmd)
      dlpoh_pkg::CMD_TICK: begin
        res3.first_low_us  = acc_q[0];
        res3.second_low_us = acc_q[1];
        res3.second_note   = sne_q;
        res3.history_note  = hnote3;
      end
      dlpoh_pkg::CMD_READ: begin
        res3.first_low_us  = rsel0;
        res3.second_low_us = rsel1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      fv_q     <= '0;
      acc_q    <= '0;
      ptr_q    <= '0;
      fill_q   <= '0;
      sec_q    <= '0;
    end else begin
      credit_q <= credit_d;
      s1_v_q   <= in_acc;
      s2_v_q   <= s1_v_q;
      s3_v_q   <= s2_v_q;
      fv_q     <= fv_d;
      acc_q    <= acc_d;
      ptr_q    <= ptr_d;
      fill_q   <= fill_d;
      sec_q    <= sec_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s1_q    <= in_i.data;
    s2_q    <= s2_d;
    s3_q    <= s3_d;
    stamp_q <= stamp_d;
    byp_q   <= byp2;
    rok_q   <= rok2;
    bp0_q   <= acc_q[0];
    bp1_q   <= acc_q[1];
  end

  // history ring
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      h0_mem[ptr_q] <= acc_q[0];
      h1_mem[ptr_q] <= acc_q[1];
    end
    rd0_q <= h0_mem[rd_addr];
    rd1_q <= h1_mem[rd_addr];
  end

  // result queue
  dlpoh_pkg::out_t    fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q, rp_q;

  always_ff @(posedge clk_i) begin
    if (s3_v_q) begin
      fifo_q[wp_q] <= res3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fcnt_q <= '0;
    end else begin
      if (s3_v_q) begin
        wp_q <= wp_q + FIFO_AW'(1);
      end
      if (out_acc) begin
        rp_q <= rp_q + FIFO_AW'(1);
      end
      fcnt_q <= fcnt_q + CNT_W'(s3_v_q) - CNT_W'(out_acc);
    end
  end

  assign out_o.valid = (fcnt_q != '0);
  assign out_o.data  = fifo_q[rp_q];

  // assertions
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q == fcnt_q + CNT_W'(s1_v_q) + CNT_W'(s2_v_q) + CNT_W'(s3_v_q))
    else $error("outstanding count out of step with pipeline and queue");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == FILL_FULL) || (fill_q == FILL_W'(ptr_q)))
    else $error("ring fill count out of step with write pointer");

  a_tick_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && (s3_q.cmd == dlpoh_pkg::CMD_TICK)) |=> (acc_q == '0))
    else $error("accumulators not cleared by tick");

  a_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_edge1 && !s1_q.level) |=> fv_q[$past(s1_q.channel)])
    else $error("falling edge did not arm its channel");

  a_sec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s3_v_q && (s3_q.cmd == dlpoh_pkg::CMD_TICK)) |=> $stable(sec_q))
    else $error("second count moved without a tick");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned HIST_DEPTH  = 64;
  localparam int unsigned TICKS_US    = 80;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned SETTLE      = 10;
  localparam int unsigned IN_W        = $bits(dlpoh_pkg::in_t);
  localparam logic [dlpoh_pkg::CMD_W-1:0]   CMD_SPARE  = 2'd3;
  localparam logic [dlpoh_pkg::TIMER_W-1:0] TIMER_MAX  = '1;
  localparam logic [dlpoh_pkg::CFG_W-1:0]   PERIOD_MAX = '1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [dlpoh_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [dlpoh_pkg::CFG_W-1:0] cfg_data_i;

  dlpoh_in_if  in_if ();
  dlpoh_out_if out_if ();

  dual_low_pulse_occupancy_history #(
    .HISTORY_DEPTH (HIST_DEPTH),
    .TICKS_PER_US  (TICKS_US)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  // occupancy state as the block should hold it
  logic [dlpoh_pkg::CFG_W-1:0]   period_cfg;
  bit                            sec_note_en;
  bit                            hist_note_en;
  logic [dlpoh_pkg::TIMER_W-1:0] fall_at [2];
  bit                            fall_armed [2];
  logic [dlpoh_pkg::ACC_W-1:0]   low_acc [2];
  logic [dlpoh_pkg::ACC_W-1:0]   hist_first [HIST_DEPTH];
  logic [dlpoh_pkg::ACC_W-1:0]   hist_second [HIST_DEPTH];
  int unsigned                   ring_wr;
  int unsigned                   hist_phase;
  logic [dlpoh_pkg::SEC_W-1:0]   sec_count;

  dlpoh_pkg::out_t owed_results [$];
  int unsigned mismatches = 0;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  logic        hold_start = 1'b0;
  int unsigned hold_left  = 0;

  // pulse generator side: pin level last sent and stamp of the last fall sent
  bit                            gen_pin_low [2] = '{1'b0, 1'b0};
  logic [dlpoh_pkg::TIMER_W-1:0] gen_fall_at [2] = '{'0, '0};

  function automatic dlpoh_pkg::out_t predict_meter(dlpoh_pkg::in_t item);
    dlpoh_pkg::out_t r;
    longint span;
    longint unsigned total;
    int unsigned slot;
    logic ch;
    r = '0;
    ch = item.channel;
    case (item.cmd)
      dlpoh_pkg::CMD_TICK: begin
        r.first_low_us  = low_acc[0];
        r.second_low_us = low_acc[1];
        sec_count = sec_count + 1;
        hist_first[ring_wr]  = low_acc[0];
        hist_second[ring_wr] = low_acc[1];
        ring_wr = (ring_wr + 1 >= HIST_DEPTH) ? 0 : ring_wr + 1;
        low_acc[0] = '0;
        low_acc[1] = '0;
        hist_phase = hist_phase + 1;
        if (hist_phase >= HIST_DEPTH) begin
          hist_phase = 0;
          r.history_note = hist_note_en;
        end
        r.second_note = sec_note_en;
      end
      dlpoh_pkg::CMD_READ: begin
        slot = (item.index >= HIST_DEPTH) ? HIST_DEPTH - 1 : item.index;
        slot = (ring_wr + slot) % HIST_DEPTH;
        r.first_low_us  = hist_first[slot];
        r.second_low_us = hist_second[slot];
      end
      default: begin
        if (item.cmd == dlpoh_pkg::CMD_EDGE) begin
          if (!item.level) begin
            fall_at[ch]    = item.timer_value;
            fall_armed[ch] = 1'b1;
          end else if (fall_armed[ch]) begin
            if (item.timer_value < fall_at[ch]) begin
              span = longint'(period_cfg) + longint'(item.timer_value) - longint'(fall_at[ch]);
            end else begin
              span = longint'(item.timer_value) - longint'(fall_at[ch]);
            end
            if (span < 0) begin
              span = 0;
            end
            total = longint'(low_acc[ch]) + span / TICKS_US;
            low_acc[ch] = (total > dlpoh_pkg::ACC_MAX) ? dlpoh_pkg::ACC_MAX :
                          total[dlpoh_pkg::ACC_W-1:0];
            fall_armed[ch] = 1'b0;
          end
        end
        r.first_low_us  = low_acc[0];
        r.second_low_us = low_acc[1];
      end
    endcase
    r.seconds_elapsed = sec_count;
    return r;
  endfunction

  task automatic flag_result(string why, dlpoh_pkg::out_t want, dlpoh_pkg::out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: want %h %h %h %b %b got %h %h %h %b %b", why,
               want.first_low_us, want.second_low_us, want.seconds_elapsed,
               want.second_note, want.history_note,
               got.first_low_us, got.second_low_us, got.seconds_elapsed,
               got.second_note, got.history_note);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    dlpoh_pkg::out_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (owed_results.size() == 0) begin
        flag_result("unexpected beat", '0, out_if.data);
      end else begin
        want = owed_results.pop_front();
        if (out_if.data.first_low_us !== want.first_low_us ||
            out_if.data.second_low_us !== want.second_low_us ||
            out_if.data.seconds_elapsed !== want.seconds_elapsed ||
            out_if.data.second_note !== want.second_note ||
            out_if.data.history_note !== want.history_note) begin
          flag_result("mismatch", want, out_if.data);
        end
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(dlpoh_pkg::in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    owed_results.push_back(predict_meter(item));
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) begin
      @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (owed_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(dlpoh_pkg::reg_e idx, logic [dlpoh_pkg::CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      dlpoh_pkg::REG_PERIOD:    period_cfg   = val;
      dlpoh_pkg::REG_SEC_NOTE:  sec_note_en  = val[0];
      dlpoh_pkg::REG_HIST_NOTE: hist_note_en = val[0];
      default: ;
    endcase
  endtask

  function automatic logic [dlpoh_pkg::CFG_W-1:0] enable_word(bit en);
    logic [dlpoh_pkg::CFG_W-1:0] w;
    w = dlpoh_pkg::CFG_W'($urandom);
    w[0] = en;
    return w;
  endfunction

  function automatic dlpoh_pkg::in_t make_item(logic [dlpoh_pkg::CMD_W-1:0] cmd, bit ch,
                                               bit lvl,
                                               logic [dlpoh_pkg::TIMER_W-1:0] stamp,
                                               logic [dlpoh_pkg::IDX_W-1:0] idx);
    dlpoh_pkg::in_t it;
    it.cmd = cmd;
    it.channel = ch;
    it.level = lvl;
    it.timer_value = stamp;
    it.index = idx;
    return it;
  endfunction

  // mostly well-formed fall/rise pairs, the rest ticks, reads and noise
  function automatic dlpoh_pkg::in_t random_item(int unsigned tick_pct, bit long_pulse);
    dlpoh_pkg::in_t it;
    logic [IN_W-1:0] raw;
    logic [dlpoh_pkg::TIMER_W-1:0] dur;
    int unsigned roll;
    logic ch;
    raw = IN_W'({$urandom, $urandom});
    it = raw;
    ch = it.channel;
    roll = $urandom_range(99);
    if (roll < tick_pct) begin
      it.cmd = dlpoh_pkg::CMD_TICK;
    end else if (roll < tick_pct + 10) begin
      it.cmd = dlpoh_pkg::CMD_READ;
    end else if (roll < tick_pct + 12) begin
      it.cmd = CMD_SPARE;
    end else if (roll < tick_pct + 20) begin
      it.cmd = dlpoh_pkg::CMD_EDGE;
    end else begin
      it.cmd = dlpoh_pkg::CMD_EDGE;
      it.level = gen_pin_low[ch];
      if (!gen_pin_low[ch]) begin
        gen_fall_at[ch] = it.timer_value;
      end else begin
        dur = long_pulse ?
              dlpoh_pkg::TIMER_W'($urandom_range(TIMER_MAX, 100_000_000)) :
              dlpoh_pkg::TIMER_W'($urandom_range(400_000));
        it.timer_value = gen_fall_at[ch] + dur;
      end
      gen_pin_low[ch] = !gen_pin_low[ch];
    end
    return it;
  endfunction

  task automatic test_directed_edges();
    send_item(make_item(dlpoh_pkg::CMD_READ, 1'b0, 1'b0, '0, 6'd0));
    send_item(make_item(dlpoh_pkg::CMD_READ, 1'b1, 1'b1, TIMER_MAX, 6'd63));
    send_item(make_item(dlpoh_pkg::CMD_EDGE, 1'b0, 1'b1, 27'd500, '0));
    send_item(make_item(dlpoh_pkg::CMD_EDGE, 1'b0, 1'b0, '0, '0));
    send_item(make_item(dlpoh_pkg::CMD_EDGE, 1'b0, 1'b1, TIMER_MAX, '1));
    send_item(make_item(dlpoh_pkg::CMD_EDGE, 1'b1, 1'b0, TIMER_MAX, '0));
    send_item(make_item(dlpoh_pkg::CMD_EDGE, 1'b1, 1'b1, '0, '0));
    send_item(make_item(dlpoh_pkg::CMD_EDGE, 1'b1, 1'b0, 27'd100, '0));
    send_item(make_item(dlpoh_pkg::CMD_EDGE, 1'b1, 1'b0, 27'd200, '0));
    send_item(make_item(dlpoh_pkg::CMD_EDGE, 1'b1, 1'b1, 27'd1000, '0));
    send_item(make_item(dlpoh_pkg::CMD_EDGE, 1'b1, 1'b1, 27'd2000, '0));
    send_item(make_item(dlpoh_pkg::CMD_EDGE, 1'b0, 1'b0, 27'd79_999_990, '0));
    send_item(make_item(dlpoh_pkg::CMD_EDGE, 1'b0, 1'b1, 27'd70, '0));
    send_item(make_item(CMD_SPARE, 1'b1, 1'b0, TIMER_MAX, '1));
    send_item(make_item(dlpoh_pkg::CMD_TICK, 1'b0, 1'b0, '0, '0));
    send_item(make_item(dlpoh_pkg::CMD_READ, 1'b0, 1'b0, '0, 6'd63));
    send_item(make_item(dlpoh_pkg::CMD_READ, 1'b0, 1'b0, '0, 6'd62));
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_reg(dlpoh_pkg::REG_PERIOD, 27'd1);
    write_reg(dlpoh_pkg::REG_SEC_NOTE, enable_word(1'b1));
    write_reg(dlpoh_pkg::REG_HIST_NOTE, enable_word(1'b1));
    send_item(make_item(dlpoh_pkg::CMD_EDGE, 1'b0, 1'b0, 27'd10, '0));
    send_item(make_item(dlpoh_pkg::CMD_EDGE, 1'b0, 1'b1, 27'd5, '0));
    send_item(make_item(dlpoh_pkg::CMD_TICK, 1'b0, 1'b0, '0, '0));
    wait_idle();
    write_reg(dlpoh_pkg::REG_PERIOD, PERIOD_MAX);
    send_item(make_item(dlpoh_pkg::CMD_EDGE, 1'b1, 1'b0, 27'd134_217_700, '0));
    send_item(make_item(dlpoh_pkg::CMD_EDGE, 1'b1, 1'b1, 27'd100, '0));
    send_item(make_item(dlpoh_pkg::CMD_TICK, 1'b1, 1'b1, TIMER_MAX, '1));
    wait_idle();
  endtask

  task automatic test_random_traffic(int unsigned n, int unsigned idle, int unsigned stall,
                                     logic [dlpoh_pkg::CFG_W-1:0] period, bit sec_en,
                                     bit hist_en, int unsigned tick_pct, bit long_pulse);
    write_reg(dlpoh_pkg::REG_PERIOD, period);
    write_reg(dlpoh_pkg::REG_SEC_NOTE, enable_word(sec_en));
    write_reg(dlpoh_pkg::REG_HIST_NOTE, enable_word(hist_en));
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) send_item(random_item(tick_pct, long_pulse));
    wait_idle();
  endtask

  task automatic test_output_hold();
    idle_pct  = 0;
    stall_pct = 0;
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    repeat (40) send_item(random_item(10, 1'b0));
    wait_idle();
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= dlpoh_pkg::REG_PERIOD;
    cfg_data_i   <= '0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    period_cfg   = dlpoh_pkg::PERIOD_RESET;
    sec_note_en  = 1'b0;
    hist_note_en = 1'b0;
    fall_at      = '{'0, '0};
    fall_armed   = '{1'b0, 1'b0};
    low_acc      = '{'0, '0};
    foreach (hist_first[i]) begin
      hist_first[i]  = '0;
      hist_second[i] = '0;
    end
    ring_wr    = 0;
    hist_phase = 0;
    sec_count  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_register_extremes();
    test_random_traffic(500, 0, 0, dlpoh_pkg::PERIOD_RESET, 1'b1, 1'b0, 8, 1'b0);
    test_random_traffic(500, 71, 0, PERIOD_MAX, 1'b0, 1'b1, 1, 1'b1);
    test_random_traffic(500, 0, 71, 27'd1, 1'b1, 1'b1, 8, 1'b0);
    test_output_hold();
    test_random_traffic(500, 18, 18,
                        dlpoh_pkg::CFG_W'($urandom_range(PERIOD_MAX, 1)),
                        1'b1, 1'b1, 10, 1'b0);

    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
